// ===== rtl/assert_macros.svh =====
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define WSF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("wsf assertion failed");

// condition that must never hold outside reset
`define WSF_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("wsf forbidden condition seen");

`endif

// ===== rtl/wsf_pkg.sv =====
// shared types, codes and constants of the wasm section framer
`default_nettype none
package wsf_pkg;

  localparam logic [1:0] KIND_SECTION = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_HDR  = 2'd1;
  localparam logic [1:0] ERR_TRUNC    = 2'd2;
  localparam logic [1:0] ERR_BAD_ID   = 2'd3;

  localparam logic [7:0] MAX_SECTION_ID = 8'd12;
  localparam logic [2:0] HDR_LAST_IDX   = 3'd7;
  localparam logic [2:0] LEB_MAX_IDX    = 3'd4;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  id;
    logic [31:0] size;
    logic [1:0]  err;
    logic        eor;
  } record_t;

  typedef struct packed {
    logic [1:0] count;
    record_t    rec0;
    record_t    rec1;
  } push_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0: val = 8'h00;
      3'd1: val = 8'h61;
      3'd2: val = 8'h73;
      3'd3: val = 8'h6d;
      3'd4: val = 8'h01;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  function automatic record_t mk_rec(input logic [1:0] kind, input logic [7:0] id,
                                     input logic [31:0] size, input logic [1:0] err);
    record_t r;
    r.kind = kind;
    r.id   = id;
    r.size = size;
    r.err  = err;
    r.eor  = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/wsf_if.sv =====
// valid/ready channel interfaces for byte input and framing records
`default_nettype none
interface wsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface wsf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [7:0]  section_id;
  logic [31:0] section_size;
  logic [1:0]  error_code;
  logic        end_of_run;

  modport source (output valid, output record_kind, output section_id,
                  output section_size, output error_code, output end_of_run,
                  input ready);
  modport sink (input valid, input record_kind, input section_id,
                input section_size, input error_code, input end_of_run,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/wsf_parse.sv =====
// framing state machine: header check, id, leb128 size, payload skip
`default_nettype none
module wsf_parse (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          fire_i,
  input  wire logic [7:0]    byte_i,
  input  wire logic          last_i,
  output wsf_pkg::push_t     push_o
);

  localparam logic [2:0] PH_MAGIC = 3'd0;
  localparam logic [2:0] PH_ID    = 3'd1;
  localparam logic [2:0] PH_LEB   = 3'd2;
  localparam logic [2:0] PH_SKIP  = 3'd3;
  localparam logic [2:0] PH_DRAIN = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [2:0]  hdr_idx_q, hdr_idx_d;
  logic [7:0]  cur_id_q, cur_id_d;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  leb_cnt_q, leb_cnt_d;
  logic [31:0] skip_q, skip_d;

  logic [2:0]  cnt_sat;
  logic [31:0] leb_part;
  logic [31:0] acc_new;
  logic [31:0] skip_dec;
  wsf_pkg::record_t rec0, rec1;
  logic [1:0]  count;

  always_comb begin
    cnt_sat = (leb_cnt_q > wsf_pkg::LEB_MAX_IDX) ? wsf_pkg::LEB_MAX_IDX : leb_cnt_q;
    case (cnt_sat)
      3'd0: leb_part = {25'd0, byte_i[6:0]};
      3'd1: leb_part = {18'd0, byte_i[6:0], 7'd0};
      3'd2: leb_part = {11'd0, byte_i[6:0], 14'd0};
      3'd3: leb_part = {4'd0, byte_i[6:0], 21'd0};
      default: leb_part = {byte_i[3:0], 28'd0};
    endcase
    acc_new  = acc_q | leb_part;
    skip_dec = (skip_q != 32'd0) ? (skip_q - 32'd1) : 32'd0;
  end

  always_comb begin
    phase_d   = phase_q;
    hdr_idx_d = hdr_idx_q;
    cur_id_d  = cur_id_q;
    acc_d     = acc_q;
    leb_cnt_d = leb_cnt_q;
    skip_d    = skip_q;
    rec0      = '0;
    rec1      = '0;
    count     = 2'd0;

    case (phase_q)
      PH_MAGIC: begin
        if (byte_i != wsf_pkg::magic_byte(hdr_idx_q)) begin
          rec0    = wsf_pkg::mk_rec(wsf_pkg::KIND_ERROR, 8'd0, 32'd0, wsf_pkg::ERR_BAD_HDR);
          count   = 2'd1;
          phase_d = PH_DRAIN;
        end else if (hdr_idx_q == wsf_pkg::HDR_LAST_IDX) begin
          phase_d = PH_ID;
          if (last_i) begin
            rec0  = wsf_pkg::mk_rec(wsf_pkg::KIND_END, 8'd0, 32'd0, wsf_pkg::ERR_NONE);
            count = 2'd1;
          end
        end else begin
          hdr_idx_d = hdr_idx_q + 3'd1;
          if (last_i) begin
            rec0  = wsf_pkg::mk_rec(wsf_pkg::KIND_ERROR, 8'd0, 32'd0, wsf_pkg::ERR_TRUNC);
            count = 2'd1;
          end
        end
      end
      PH_ID: begin
        cur_id_d = byte_i;
        if (byte_i > wsf_pkg::MAX_SECTION_ID) begin
          rec0    = wsf_pkg::mk_rec(wsf_pkg::KIND_ERROR, byte_i, 32'd0, wsf_pkg::ERR_BAD_ID);
          count   = 2'd1;
          phase_d = PH_DRAIN;
        end else begin
          acc_d     = 32'd0;
          leb_cnt_d = 3'd0;
          phase_d   = PH_LEB;
          if (last_i) begin
            rec0  = wsf_pkg::mk_rec(wsf_pkg::KIND_ERROR, 8'd0, 32'd0, wsf_pkg::ERR_TRUNC);
            count = 2'd1;
          end
        end
      end
      PH_LEB: begin
        acc_d     = acc_new;
        leb_cnt_d = cnt_sat + 3'd1;
        if (!byte_i[7] || (cnt_sat == wsf_pkg::LEB_MAX_IDX)) begin
          rec0    = wsf_pkg::mk_rec(wsf_pkg::KIND_SECTION, cur_id_q, acc_new,
                                    wsf_pkg::ERR_NONE);
          count   = 2'd1;
          skip_d  = acc_new;
          phase_d = (acc_new == 32'd0) ? PH_ID : PH_SKIP;
          if (last_i) begin
            count = 2'd2;
            if (acc_new == 32'd0) begin
              rec1 = wsf_pkg::mk_rec(wsf_pkg::KIND_END, 8'd0, 32'd0, wsf_pkg::ERR_NONE);
            end else begin
              rec1 = wsf_pkg::mk_rec(wsf_pkg::KIND_ERROR, 8'd0, 32'd0, wsf_pkg::ERR_TRUNC);
            end
          end
        end else if (last_i) begin
          rec0  = wsf_pkg::mk_rec(wsf_pkg::KIND_ERROR, 8'd0, 32'd0, wsf_pkg::ERR_TRUNC);
          count = 2'd1;
        end
      end
      PH_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == 32'd0) begin
          phase_d = PH_ID;
        end
        if (last_i) begin
          count = 2'd1;
          if (skip_dec == 32'd0) begin
            rec0 = wsf_pkg::mk_rec(wsf_pkg::KIND_END, 8'd0, 32'd0, wsf_pkg::ERR_NONE);
          end else begin
            rec0 = wsf_pkg::mk_rec(wsf_pkg::KIND_ERROR, 8'd0, 32'd0, wsf_pkg::ERR_TRUNC);
          end
        end
      end
      default: begin
        phase_d = PH_DRAIN;
      end
    endcase

    if (last_i) begin
      phase_d   = PH_MAGIC;
      hdr_idx_d = 3'd0;
      cur_id_d  = 8'd0;
      acc_d     = 32'd0;
      leb_cnt_d = 3'd0;
      skip_d    = 32'd0;
    end

    if (count == 2'd1) begin
      rec0.eor = 1'b1;
    end
    if (count == 2'd2) begin
      rec1.eor = 1'b1;
    end

    push_o.count = fire_i ? count : 2'd0;
    push_o.rec0  = rec0;
    push_o.rec1  = rec1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_MAGIC;
      hdr_idx_q <= 3'd0;
      cur_id_q  <= 8'd0;
      acc_q     <= 32'd0;
      leb_cnt_q <= 3'd0;
      skip_q    <= 32'd0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      hdr_idx_q <= hdr_idx_d;
      cur_id_q  <= cur_id_d;
      acc_q     <= acc_d;
      leb_cnt_q <= leb_cnt_d;
      skip_q    <= skip_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/wsf_outq.sv =====
// record queue: up to two writes and one read per cycle
`default_nettype none
module wsf_outq (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire wsf_pkg::push_t   push_i,
  output logic                  room_o,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output wsf_pkg::record_t      rec_o
);

  wsf_pkg::record_t mem_q [wsf_pkg::QUEUE_DEPTH];
  logic [wsf_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_p1;
  logic [wsf_pkg::QPTR_W:0]   fill_q;
  logic                       pop;

  assign wr_ptr_p1 = wr_ptr_q + 1'b1;
  assign pop       = valid_o && ready_i;
  assign valid_o   = fill_q != '0;
  assign room_o    = fill_q <= (wsf_pkg::QPTR_W + 1)'(wsf_pkg::QUEUE_DEPTH - 2);
  assign rec_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.rec0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_p1] <= push_i.rec1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_i.count[wsf_pkg::QPTR_W-1:0];
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      fill_q <= fill_q + (wsf_pkg::QPTR_W + 1)'(push_i.count)
                - (wsf_pkg::QPTR_W + 1)'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/wasm_section_framer_core.sv =====
// top level of the wasm section framer: input stage, framer, record queue
//
//  channel  dir  beat contents
//  in_i     in   data_byte, last
//  out_o    out  record_kind, section_id, section_size, error_code, end_of_run
//
// one byte per cycle while the queue has room; each accepted byte waits in the input register until framed
// a final byte that completes a size can yield two records, queued together
// bytes stall only while three or more records wait in the four-entry queue
// reset returns to the magic check with an empty queue
`default_nettype none
module wasm_section_framer_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  wsf_in_if.sink     in_i,
  wsf_out_if.source  out_o
);

  logic             in_vld_q;
  logic [7:0]       in_byte_q;
  logic             in_last_q;
  logic             room;
  logic             fire;
  wsf_pkg::push_t   push;
  wsf_pkg::record_t rec;

  assign fire       = in_vld_q && room;
  assign in_i.ready = !in_vld_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.data_byte;
      in_last_q <= in_i.last;
    end
  end

  wsf_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .push_o (push)
  );

  wsf_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .rec_o   (rec)
  );

  assign out_o.record_kind  = rec.kind;
  assign out_o.section_id   = rec.id;
  assign out_o.section_size = rec.size;
  assign out_o.error_code   = rec.err;
  assign out_o.end_of_run   = rec.eor;

endmodule
`default_nettype wire

// ===== rtl/wsf_checker.sv =====
// port-level assertions for the wasm section framer and their binding
`default_nettype none
`include "assert_macros.svh"
module wsf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [1:0]  kind_i,
  input wire logic [31:0] size_i,
  input wire logic [1:0]  err_i,
  input wire logic        eor_i
);

  `WSF_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(kind_i) && $stable(size_i) && $stable(err_i)))
  `WSF_NEVER(a_end_marks_run, clk_i, rst_ni, out_valid_i && (kind_i == wsf_pkg::KIND_END) && !eor_i)
  `WSF_NEVER(a_section_no_err, clk_i, rst_ni, out_valid_i && (kind_i == wsf_pkg::KIND_SECTION) && (err_i != wsf_pkg::ERR_NONE))
  `WSF_NEVER(a_error_coded, clk_i, rst_ni, out_valid_i && (kind_i == wsf_pkg::KIND_ERROR) && ((err_i == wsf_pkg::ERR_NONE) || !eor_i))

endmodule

bind wasm_section_framer_core wsf_checker u_wsf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .kind_i      (out_o.record_kind),
  .size_i      (out_o.section_size),
  .err_i       (out_o.error_code),
  .eor_i       (out_o.end_of_run)
);
`default_nettype wire
